@@ design/lpop_pkg.sv @@
// Package for the length-prefixed object parser.
// Holds the result record, the result kind and error codes, and the parser phase type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lpop_pkg;

    localparam logic [2:0] KIND_STR_HDR  = 3'd0;
    localparam logic [2:0] KIND_STR_BYTE = 3'd1;
    localparam logic [2:0] KIND_INT      = 3'd2;
    localparam logic [2:0] KIND_CMP_HDR  = 3'd3;
    localparam logic [2:0] KIND_CMP_BYTE = 3'd4;
    localparam logic [2:0] KIND_ERROR    = 3'd5;

    localparam logic [1:0] CAUSE_UNKNOWN_ENC = 2'd0;
    localparam logic [1:0] CAUSE_TRUNCATED   = 2'd1;
    localparam logic [1:0] CAUSE_LEN_ERROR   = 2'd2;

    // Top two bits of a first length byte.
    localparam logic [1:0] FORM_LEN6  = 2'd0;
    localparam logic [1:0] FORM_LEN14 = 2'd1;
    localparam logic [1:0] FORM_LEN32 = 2'd2;
    localparam logic [1:0] FORM_ENC   = 2'd3;

    // Marker codes after the encoding form.
    localparam logic [5:0] ENC_INT8  = 6'd0;
    localparam logic [5:0] ENC_INT16 = 6'd1;
    localparam logic [5:0] ENC_INT32 = 6'd2;
    localparam logic [5:0] ENC_CMP   = 6'd3;

    localparam logic [31:0] LEN_ERROR_VALUE = 32'hFFFF_FFFF;

    typedef enum logic [3:0] {
        PH_STR_FIRST = 4'd0,
        PH_STR_B2    = 4'd1,
        PH_STR_B4    = 4'd2,
        PH_CMP_FIRST = 4'd3,
        PH_CMP_B2    = 4'd4,
        PH_CMP_B4    = 4'd5,
        PH_RAW_FIRST = 4'd6,
        PH_RAW_B2    = 4'd7,
        PH_RAW_B4    = 4'd8,
        PH_INT       = 4'd9,
        PH_STR_PAY   = 4'd10,
        PH_CMP_PAY   = 4'd11
    } phase_t;

    typedef struct packed {
        logic [2:0]         kind;
        logic [31:0]        length;
        logic [31:0]        raw_length;
        logic signed [31:0] int_value;
        logic [7:0]         data_byte;
        logic [1:0]         error_cause;
        logic               last;
    } result_t;

endpackage

`default_nettype wire

@@ design/length_prefixed_object_parser.sv @@
// Top level of the length-prefixed object parser: front end, result queue and
// output stage. Depends on lpop_pkg, lpop_front, lpop_queue and lpop_back.
`timescale 1ns / 1ps
`default_nettype none

// Parses a stream of length-prefixed string objects, one byte per request, and
// produces string headers and bytes, sign-extended integers, compressed-blob
// headers and bytes, or errors. The block takes one byte every cycle while the
// queue is not full; the parser updates its registered phase from each byte.
// A result is written into a QUEUE_DEPTH-entry queue and then loaded into the
// output register that drives out_valid. Input requests stall only while the
// queue is full, so a slow consumer back-pressures the input after
// QUEUE_DEPTH + 1 results are pending. Bytes that complete no result (length
// and integer bytes being gathered) produce nothing.

module length_prefixed_object_parser
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [7:0]         in_byte,
    input  wire logic               stream_end,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [2:0]              kind,
    output logic [31:0]             length,
    output logic [31:0]             raw_length,
    output logic signed [31:0]      int_value,
    output logic [7:0]              data_byte,
    output logic [1:0]              error_cause,
    output logic                    last
);
    import lpop_pkg::*;

    logic    q_full;
    logic    q_empty;
    logic    q_pop;
    logic    front_valid;
    result_t front_res;
    result_t q_data;
    result_t out_res;

    lpop_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .stream_end (stream_end),
        .q_full     (q_full),
        .res_valid  (front_valid),
        .res        (front_res)
    );

    lpop_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_valid),
        .push_data (front_res),
        .pop       (q_pop),
        .pop_data  (q_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    lpop_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res       (out_res)
    );

    assign kind        = out_res.kind;
    assign length      = out_res.length;
    assign raw_length  = out_res.raw_length;
    assign int_value   = out_res.int_value;
    assign data_byte   = out_res.data_byte;
    assign error_cause = out_res.error_cause;
    assign last        = out_res.last;

`ifndef ASSERT_OFF
    // The front end never produces a result while the queue has no room.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        front_valid |-> !q_full)
        else $error("result pushed into a full queue");

    // Every error closes its object.
    a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
        (front_valid && (front_res.kind == KIND_ERROR)) |-> front_res.last)
        else $error("error result without last");

    // A taken result with more waiting in the queue is followed at once.
    a_back_refill: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !q_empty) |=> out_valid)
        else $error("output stage failed to refill from the queue");
`endif

endmodule

`default_nettype wire

@@ design/lpop_front.sv @@
// Front end of the parser: accepts stream bytes, tracks the object phase and
// builds at most one result record per byte. Depends on lpop_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lpop_front
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic [7:0]      in_byte,
    input  wire logic            stream_end,
    input  wire logic            q_full,
    output logic                 res_valid,
    output lpop_pkg::result_t    res
);
    import lpop_pkg::*;

    localparam logic [1:0] CTX_STR = 2'd0;
    localparam logic [1:0] CTX_CMP = 2'd1;
    localparam logic [1:0] CTX_RAW = 2'd2;

    phase_t      phase_reg, phase_next;
    logic [31:0] gath_reg, gath_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [1:0]  iwk_reg, iwk_next;
    logic [31:0] saved_reg, saved_next;
    logic [31:0] rem_reg, rem_next;

    logic        take;
    logic [1:0]  form;
    logic [5:0]  low;
    logic [1:0]  ctx;
    logic        first_ph;
    logic        len_done;
    logic [31:0] len_val;
    logic        len_err;
    logic [2:0]  cnt_dec;
    logic        cnt_done;
    logic [2:0]  int_total;
    logic [1:0]  int_idx;
    logic [31:0] gath_ins;
    logic [31:0] int_ext;
    logic [31:0] rem_dec;

    function automatic phase_t phase_b2(input logic [1:0] c);
        phase_t p;
        case (c)
            CTX_STR: p = PH_STR_B2;
            CTX_CMP: p = PH_CMP_B2;
            default: p = PH_RAW_B2;
        endcase
        return p;
    endfunction

    function automatic phase_t phase_b4(input logic [1:0] c);
        phase_t p;
        case (c)
            CTX_STR: p = PH_STR_B4;
            CTX_CMP: p = PH_CMP_B4;
            default: p = PH_RAW_B4;
        endcase
        return p;
    endfunction

    assign in_ready = !q_full;
    assign take     = in_valid && in_ready;
    assign form     = in_byte[7:6];
    assign low      = in_byte[5:0];
    assign cnt_dec  = cnt_reg - 3'd1;
    // A gather finishes when the count runs out or wraps past the longest form.
    assign cnt_done = (cnt_dec == 3'd0) || (cnt_dec > 3'd4);
    assign rem_dec  = rem_reg - 32'd1;
    // Only a first length byte is decoded by its form; later length bytes are data.
    assign first_ph = (phase_reg == PH_STR_FIRST) || (phase_reg == PH_CMP_FIRST) ||
                      (phase_reg == PH_RAW_FIRST);

    // Length gathering shared by the three length contexts.
    always_comb
    begin
        ctx      = CTX_STR;
        len_done = 1'b0;
        len_val  = {26'd0, low};
        case (phase_reg)
            PH_CMP_FIRST, PH_CMP_B2, PH_CMP_B4: ctx = CTX_CMP;
            PH_RAW_FIRST, PH_RAW_B2, PH_RAW_B4: ctx = CTX_RAW;
            default:                            ctx = CTX_STR;
        endcase
        case (phase_reg)
            PH_STR_FIRST, PH_CMP_FIRST, PH_RAW_FIRST:
            begin
                // Inside a compressed blob the encoding form reads as a 6-bit length.
                len_done = (form == FORM_LEN6) || ((form == FORM_ENC) && (ctx != CTX_STR));
                len_val  = {26'd0, low};
            end
            PH_STR_B2, PH_CMP_B2, PH_RAW_B2:
            begin
                len_done = 1'b1;
                len_val  = {18'd0, gath_reg[5:0], in_byte};
            end
            PH_STR_B4, PH_CMP_B4, PH_RAW_B4:
            begin
                len_done = cnt_done;
                len_val  = {gath_reg[23:0], in_byte};
            end
            default:
            begin
                len_done = 1'b0;
                len_val  = {26'd0, low};
            end
        endcase
    end

    assign len_err = len_done && (len_val == LEN_ERROR_VALUE);

    // Little-endian integer gather and sign extension.
    always_comb
    begin
        case (iwk_reg)
            2'd0:    int_total = 3'd1;
            2'd1:    int_total = 3'd2;
            default: int_total = 3'd4;
        endcase
        int_idx  = 2'(int_total - cnt_reg);
        gath_ins = gath_reg | ({24'd0, in_byte} << {int_idx, 3'b000});
        int_ext  = gath_ins;
        if ((int_total == 3'd1) && gath_ins[7])
        begin
            int_ext = gath_ins | 32'hFFFF_FF00;
        end
        else if ((int_total == 3'd2) && gath_ins[15])
        begin
            int_ext = gath_ins | 32'hFFFF_0000;
        end
    end

    // Next state.
    always_comb
    begin
        phase_next = phase_reg;
        gath_next  = gath_reg;
        cnt_next   = cnt_reg;
        iwk_next   = iwk_reg;
        saved_next = saved_reg;
        rem_next   = rem_reg;
        if (take)
        begin
            if (stream_end)
            begin
                phase_next = PH_STR_FIRST;
            end
            else
            begin
                case (phase_reg)
                    PH_STR_FIRST, PH_CMP_FIRST, PH_RAW_FIRST,
                    PH_STR_B2, PH_CMP_B2, PH_RAW_B2,
                    PH_STR_B4, PH_CMP_B4, PH_RAW_B4:
                    begin
                        if ((phase_reg == PH_STR_B4) || (phase_reg == PH_CMP_B4) ||
                            (phase_reg == PH_RAW_B4))
                        begin
                            gath_next = len_val;
                            cnt_next  = cnt_dec;
                        end
                        if (len_done)
                        begin
                            if (len_err)
                            begin
                                phase_next = PH_STR_FIRST;
                            end
                            else if (ctx == CTX_STR)
                            begin
                                rem_next   = len_val;
                                phase_next = (len_val != 32'd0) ? PH_STR_PAY : PH_STR_FIRST;
                            end
                            else if (ctx == CTX_CMP)
                            begin
                                saved_next = len_val;
                                phase_next = PH_RAW_FIRST;
                            end
                            else
                            begin
                                rem_next   = saved_reg;
                                phase_next = (saved_reg != 32'd0) ? PH_CMP_PAY : PH_STR_FIRST;
                            end
                        end
                        else if (first_ph)
                        begin
                            if (form == FORM_LEN14)
                            begin
                                gath_next  = {26'd0, low};
                                phase_next = phase_b2(ctx);
                            end
                            else if (form == FORM_LEN32)
                            begin
                                gath_next  = 32'd0;
                                cnt_next   = 3'd4;
                                phase_next = phase_b4(ctx);
                            end
                            else if ((low == ENC_INT8) || (low == ENC_INT16) ||
                                     (low == ENC_INT32))
                            begin
                                iwk_next   = low[1:0];
                                gath_next  = 32'd0;
                                cnt_next   = (low == ENC_INT8) ? 3'd1 :
                                             ((low == ENC_INT16) ? 3'd2 : 3'd4);
                                phase_next = PH_INT;
                            end
                            else if (low == ENC_CMP)
                            begin
                                phase_next = PH_CMP_FIRST;
                            end
                            else
                            begin
                                phase_next = PH_STR_FIRST;
                            end
                        end
                    end
                    PH_INT:
                    begin
                        gath_next = gath_ins;
                        cnt_next  = cnt_dec;
                        if (cnt_done)
                        begin
                            phase_next = PH_STR_FIRST;
                        end
                    end
                    PH_STR_PAY, PH_CMP_PAY:
                    begin
                        rem_next = rem_dec;
                        if (rem_dec == 32'd0)
                        begin
                            phase_next = PH_STR_FIRST;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_STR_FIRST;
                    end
                endcase
            end
        end
    end

    // Result record.
    always_comb
    begin
        res_valid = 1'b0;
        res       = '0;
        if (take)
        begin
            if (stream_end)
            begin
                if (phase_reg != PH_STR_FIRST)
                begin
                    res_valid       = 1'b1;
                    res.kind        = KIND_ERROR;
                    res.error_cause = CAUSE_TRUNCATED;
                    res.last        = 1'b1;
                end
            end
            else
            begin
                case (phase_reg)
                    PH_STR_FIRST, PH_CMP_FIRST, PH_RAW_FIRST,
                    PH_STR_B2, PH_CMP_B2, PH_RAW_B2,
                    PH_STR_B4, PH_CMP_B4, PH_RAW_B4:
                    begin
                        if (len_done)
                        begin
                            if (len_err)
                            begin
                                res_valid       = 1'b1;
                                res.kind        = KIND_ERROR;
                                res.error_cause = CAUSE_LEN_ERROR;
                                res.last        = 1'b1;
                            end
                            else if (ctx == CTX_STR)
                            begin
                                res_valid  = 1'b1;
                                res.kind   = KIND_STR_HDR;
                                res.length = len_val;
                                res.last   = (len_val == 32'd0);
                            end
                            else if (ctx == CTX_RAW)
                            begin
                                res_valid      = 1'b1;
                                res.kind       = KIND_CMP_HDR;
                                res.length     = saved_reg;
                                res.raw_length = len_val;
                                res.last       = (saved_reg == 32'd0);
                            end
                        end
                        else if (first_ph && (form == FORM_ENC) && (low > ENC_CMP))
                        begin
                            res_valid       = 1'b1;
                            res.kind        = KIND_ERROR;
                            res.error_cause = CAUSE_UNKNOWN_ENC;
                            res.last        = 1'b1;
                        end
                    end
                    PH_INT:
                    begin
                        if (cnt_done)
                        begin
                            res_valid     = 1'b1;
                            res.kind      = KIND_INT;
                            res.int_value = int_ext;
                            res.last      = 1'b1;
                        end
                    end
                    PH_STR_PAY, PH_CMP_PAY:
                    begin
                        res_valid     = 1'b1;
                        res.kind      = (phase_reg == PH_STR_PAY) ? KIND_STR_BYTE : KIND_CMP_BYTE;
                        res.data_byte = in_byte;
                        res.last      = (rem_dec == 32'd0);
                    end
                    default:
                    begin
                        res_valid = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_STR_FIRST;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        gath_reg  <= gath_next;
        cnt_reg   <= cnt_next;
        iwk_reg   <= iwk_next;
        saved_reg <= saved_next;
        rem_reg   <= rem_next;
    end

endmodule

`default_nettype wire

@@ design/lpop_queue.sv @@
// Short result queue between the parser front end and the output stage.
// Register-based circular buffer of result records. Depends on lpop_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lpop_queue
#(
    parameter int DEPTH = 2
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire lpop_pkg::result_t  push_data,
    input  wire logic               pop,
    output lpop_pkg::result_t       pop_data,
    output logic                    full,
    output logic                    empty
);
    import lpop_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    result_t          mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_FULL);
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

@@ design/lpop_back.sv @@
// Output stage of the parser: pulls result records from the queue into an
// output register and hands them out on the result channel. Depends on lpop_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lpop_back
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               q_empty,
    input  wire lpop_pkg::result_t  q_data,
    output logic                    q_pop,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output lpop_pkg::result_t       res
);
    import lpop_pkg::*;

    logic    valid_reg, valid_next;
    result_t res_reg;

    // The output register refills from a non-empty queue when empty or taken.
    assign q_pop      = !q_empty && (!valid_reg || out_ready);
    assign valid_next = q_pop || (valid_reg && !out_ready);
    assign out_valid  = valid_reg;
    assign res        = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            res_reg <= q_data;
        end
    end

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// Testbench for length_prefixed_object_parser: a table of directed requests, then random
// encoded objects, each result checked against its table entry or a predictor of the parser.
// Depends on lpop_pkg and the parser RTL.
`timescale 1ns / 1ps

module tb;
    import lpop_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_ITEMS  = 380;
    localparam int HOLD_CYCLES   = 80;
    localparam int MAX_PRINTED   = 40;

    typedef enum logic [1:0] {CTX_STR, CTX_CMP, CTX_RAW} ctx_t;

    typedef struct packed {
        logic [7:0] b;
        logic       fin;
    } req_t;

    typedef struct packed {
        logic [7:0] b;
        logic       fin;
        logic       typed;
        logic       hit;
        result_t    want;
    } stim_row_t;

    logic               clk;
    logic               rst_n       = 1'b0;
    logic               in_valid    = 1'b0;
    logic               in_ready;
    logic [7:0]         in_byte     = 8'h00;
    logic               stream_end  = 1'b0;
    logic               out_valid;
    logic               out_ready   = 1'b0;
    logic [2:0]         kind;
    logic [31:0]        length;
    logic [31:0]        raw_length;
    logic signed [31:0] int_value;
    logic [7:0]         data_byte;
    logic [1:0]         error_cause;
    logic               last;

    // Side-band copy of the directed row, so that the monitor sees it with its request.
    logic               row_typed   = 1'b0;
    logic               row_hit     = 1'b0;
    result_t            row_want    = '0;

    // Predictor state.
    phase_t             prs_phase;
    logic [31:0]        prs_acc;
    logic [2:0]         prs_left;
    logic [5:0]         prs_int_code;
    logic [31:0]        prs_cmp_len;
    logic [31:0]        prs_pay_left;

    result_t            awaited_results[$];
    stim_row_t          directed_rows[$];
    req_t               obj_reqs[$];

    int                 diff_count      = 0;
    int                 requests_sent   = 0;
    int                 requests_taken  = 0;
    int                 results_checked = 0;
    int                 idle_cycles     = 0;
    bit                 long_hold_done  = 1'b0;
    bit                 step_hit;
    result_t            step_res;
    result_t            got_res;

    length_prefixed_object_parser i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_byte     (in_byte),
        .stream_end  (stream_end),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .length      (length),
        .raw_length  (raw_length),
        .int_value   (int_value),
        .data_byte   (data_byte),
        .error_cause (error_cause),
        .last        (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------- predictor

    task automatic parser_clear();
        prs_phase    = PH_STR_FIRST;
        prs_acc      = '0;
        prs_left     = '0;
        prs_int_code = ENC_INT8;
        prs_cmp_len  = '0;
        prs_pay_left = '0;
    endtask

    task automatic raise_error(input logic [1:0] cause, output bit hit, output result_t r);
        parser_clear();
        r             = '0;
        r.kind        = KIND_ERROR;
        r.error_cause = cause;
        r.last        = 1'b1;
        hit           = 1'b1;
    endtask

    function automatic ctx_t context_of(phase_t ph);
        case (ph)
            PH_CMP_FIRST, PH_CMP_B2, PH_CMP_B4: return CTX_CMP;
            PH_RAW_FIRST, PH_RAW_B2, PH_RAW_B4: return CTX_RAW;
            default: return CTX_STR;
        endcase
    endfunction

    task automatic close_length(input ctx_t ctx, input logic [31:0] value,
                                output bit hit, output result_t r);
        r   = '0;
        hit = 1'b0;
        if (value == LEN_ERROR_VALUE)
        begin
            raise_error(CAUSE_LEN_ERROR, hit, r);
        end
        else if (ctx == CTX_STR)
        begin
            r.kind       = KIND_STR_HDR;
            r.length     = value;
            r.last       = (value == 0);
            hit          = 1'b1;
            prs_pay_left = value;
            if (value != 0)
                prs_phase = PH_STR_PAY;
            else
                prs_phase = PH_STR_FIRST;
        end
        else if (ctx == CTX_CMP)
        begin
            // The compressed length is held until the uncompressed one arrives.
            prs_cmp_len = value;
            prs_phase   = PH_RAW_FIRST;
        end
        else
        begin
            r.kind       = KIND_CMP_HDR;
            r.length     = prs_cmp_len;
            r.raw_length = value;
            r.last       = (prs_cmp_len == 0);
            hit          = 1'b1;
            prs_pay_left = prs_cmp_len;
            if (prs_cmp_len != 0)
                prs_phase = PH_CMP_PAY;
            else
                prs_phase = PH_STR_FIRST;
        end
    endtask

    task automatic parse_stream_byte(input logic [7:0] b, input logic fin,
                                     output bit hit, output result_t r);
        logic [1:0]  form;
        logic [5:0]  low;
        logic [31:0] v;
        int          nbytes;
        form = b[7:6];
        low  = b[5:0];
        r    = '0;
        hit  = 1'b0;
        if (fin)
        begin
            // A stream end between objects is silent; inside one it is a truncation.
            if (prs_phase != PH_STR_FIRST)
                raise_error(CAUSE_TRUNCATED, hit, r);
        end
        else
        begin
            case (prs_phase)
                PH_INT:
                begin
                    if (prs_int_code == ENC_INT8)
                        nbytes = 1;
                    else if (prs_int_code == ENC_INT16)
                        nbytes = 2;
                    else
                        nbytes = 4;
                    prs_acc  = prs_acc | ({24'd0, b} << (8 * (nbytes - prs_left)));
                    prs_left = prs_left - 3'd1;
                    if (prs_left == 0)
                    begin
                        v = prs_acc;
                        if (nbytes == 1)
                            v = {{24{v[7]}}, v[7:0]};
                        else if (nbytes == 2)
                            v = {{16{v[15]}}, v[15:0]};
                        parser_clear();
                        r.kind      = KIND_INT;
                        r.int_value = v;
                        r.last      = 1'b1;
                        hit         = 1'b1;
                    end
                end
                PH_STR_PAY, PH_CMP_PAY:
                begin
                    prs_pay_left = prs_pay_left - 32'd1;
                    if (prs_phase == PH_STR_PAY)
                        r.kind = KIND_STR_BYTE;
                    else
                        r.kind = KIND_CMP_BYTE;
                    r.data_byte = b;
                    r.last      = (prs_pay_left == 0);
                    hit         = 1'b1;
                    if (prs_pay_left == 0)
                        prs_phase = PH_STR_FIRST;
                end
                PH_STR_FIRST, PH_CMP_FIRST, PH_RAW_FIRST:
                begin
                    // Inside a compressed header the encoding form reads as a 6-bit length.
                    if (form == FORM_LEN6 || (form == FORM_ENC && prs_phase != PH_STR_FIRST))
                    begin
                        close_length(context_of(prs_phase), {26'd0, low}, hit, r);
                    end
                    else if (form == FORM_LEN14)
                    begin
                        prs_acc   = {26'd0, low};
                        prs_phase = phase_t'(prs_phase + 4'd1);
                    end
                    else if (form == FORM_LEN32)
                    begin
                        prs_acc   = '0;
                        prs_left  = 3'd4;
                        prs_phase = phase_t'(prs_phase + 4'd2);
                    end
                    else if (low == ENC_INT8 || low == ENC_INT16 || low == ENC_INT32)
                    begin
                        prs_int_code = low;
                        if (low == ENC_INT8)
                            prs_left = 3'd1;
                        else if (low == ENC_INT16)
                            prs_left = 3'd2;
                        else
                            prs_left = 3'd4;
                        prs_acc   = '0;
                        prs_phase = PH_INT;
                    end
                    else if (low == ENC_CMP)
                    begin
                        prs_phase = PH_CMP_FIRST;
                    end
                    else
                    begin
                        raise_error(CAUSE_UNKNOWN_ENC, hit, r);
                    end
                end
                PH_STR_B2, PH_CMP_B2, PH_RAW_B2:
                begin
                    close_length(context_of(prs_phase), {18'd0, prs_acc[5:0], b}, hit, r);
                end
                default:
                begin
                    // Big-endian four-byte length.
                    prs_acc  = {prs_acc[23:0], b};
                    prs_left = prs_left - 3'd1;
                    if (prs_left == 0)
                        close_length(context_of(prs_phase), prs_acc, hit, r);
                end
            endcase
        end
    endtask

    // ---------------------------------------------------------------- checking

    task automatic report_diff(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (diff_count < MAX_PRINTED)
            $display("%0t ns: %s: got 0x%08h, expected 0x%08h", $time, what, got, want);
        diff_count++;
    endtask

    task automatic compare_result(input result_t got, input result_t want);
        if (got.kind != want.kind)
            report_diff("kind", 32'(got.kind), 32'(want.kind));
        if (got.length != want.length)
            report_diff("length", got.length, want.length);
        if (got.raw_length != want.raw_length)
            report_diff("raw_length", got.raw_length, want.raw_length);
        if (got.int_value != want.int_value)
            report_diff("int_value", got.int_value, want.int_value);
        if (got.data_byte != want.data_byte)
            report_diff("data_byte", 32'(got.data_byte), 32'(want.data_byte));
        if (got.error_cause != want.error_cause)
            report_diff("error_cause", 32'(got.error_cause), 32'(want.error_cause));
        if (got.last != want.last)
            report_diff("last", 32'(got.last), 32'(want.last));
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                parse_stream_byte(in_byte, stream_end, step_hit, step_res);
                if (row_typed)
                begin
                    if (row_hit)
                        awaited_results.push_back(row_want);
                end
                else if (step_hit)
                begin
                    awaited_results.push_back(step_res);
                end
                requests_taken++;
            end
            if (out_valid && out_ready)
            begin
                got_res = {kind, length, raw_length, int_value, data_byte, error_cause, last};
                if (awaited_results.size() == 0)
                    report_diff("result with none awaited, kind", 32'(got_res.kind), '0);
                else
                    compare_result(got_res, awaited_results.pop_front());
                results_checked++;
            end
        end
    end

    // Ends the run when the handshakes stop moving altogether.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Watchdog: no handshake for %0d cycles, %0d results still awaited",
                         STALL_LIMIT, awaited_results.size());
                $display("Mismatches found");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    function automatic result_t mk_result(logic [2:0] k, logic [31:0] len, logic [31:0] raw,
                                          logic [31:0] ival, logic [7:0] db,
                                          logic [1:0] cause, logic lst);
        result_t r;
        r = {k, len, raw, ival, db, cause, lst};
        return r;
    endfunction

    function automatic stim_row_t table_row(logic [7:0] b, logic fin, logic typed,
                                            logic hit, result_t want);
        stim_row_t row;
        row = {b, fin, typed, hit, want};
        return row;
    endfunction

    function automatic void push_req(logic [7:0] b, logic fin);
        obj_reqs.push_back({b, fin});
    endfunction

    function automatic void push_length(logic [31:0] v, bit inner);
        int         form;
        logic [5:0] pad;
        pad = 6'($urandom_range(0, 63));
        if (v < 64)
            form = $urandom_range(0, inner ? 3 : 2);
        else if (v < 16384)
            form = $urandom_range(1, 2);
        else
            form = 2;
        case (form)
            0: push_req({FORM_LEN6, v[5:0]}, 1'b0);
            1:
            begin
                push_req({FORM_LEN14, v[13:8]}, 1'b0);
                push_req(v[7:0], 1'b0);
            end
            2:
            begin
                push_req({FORM_LEN32, pad}, 1'b0);
                push_req(v[31:24], 1'b0);
                push_req(v[23:16], 1'b0);
                push_req(v[15:8], 1'b0);
                push_req(v[7:0], 1'b0);
            end
            default: push_req({FORM_ENC, v[5:0]}, 1'b0);
        endcase
    endfunction

    function automatic int pick_payload_size();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, 300);
        return $urandom_range(0, 8);
    endfunction

    // sort: 0 plain string, 1 integer, 2 compressed blob
    function automatic void push_object(int sort);
        int          n;
        int          r;
        logic [5:0]  code;
        logic [31:0] clen;
        logic [31:0] raw;
        if (sort == 0)
        begin
            n = pick_payload_size();
            push_length(n, 1'b0);
            repeat (n) push_req(8'($urandom_range(0, 255)), 1'b0);
        end
        else if (sort == 1)
        begin
            r = $urandom_range(0, 2);
            if (r == 0)
            begin
                code = ENC_INT8;
                n    = 1;
            end
            else if (r == 1)
            begin
                code = ENC_INT16;
                n    = 2;
            end
            else
            begin
                code = ENC_INT32;
                n    = 4;
            end
            push_req({FORM_ENC, code}, 1'b0);
            repeat (n) push_req(8'($urandom_range(0, 255)), 1'b0);
        end
        else
        begin
            push_req({FORM_ENC, ENC_CMP}, 1'b0);
            if ($urandom_range(0, 19) == 0)
                clen = LEN_ERROR_VALUE;
            else
                clen = pick_payload_size();
            push_length(clen, 1'b1);
            if (clen != LEN_ERROR_VALUE)
            begin
                r = $urandom_range(0, 19);
                if (r == 0)
                    raw = LEN_ERROR_VALUE;
                else if (r <= 3)
                    raw = $urandom;
                else if (r <= 7)
                    raw = $urandom_range(0, 16383);
                else
                    raw = $urandom_range(0, 200);
                push_length(raw, 1'b1);
                if (raw != LEN_ERROR_VALUE)
                    repeat (clen) push_req(8'($urandom_range(0, 255)), 1'b0);
            end
        end
    endfunction

    // Mostly well-formed objects with random content; the rest is errors and noise.
    function automatic void gen_object();
        int         pick;
        int         cut;
        logic [5:0] bits6;
        pick  = $urandom_range(0, 99);
        bits6 = 6'($urandom_range(0, 63));
        obj_reqs.delete();
        if (pick < 30)
        begin
            push_object(0);
        end
        else if (pick < 50)
        begin
            push_object(1);
        end
        else if (pick < 70)
        begin
            push_object(2);
        end
        else if (pick < 75)
        begin
            push_req({FORM_LEN32, bits6}, 1'b0);
            repeat (4) push_req(8'hFF, 1'b0);
        end
        else if (pick < 80)
        begin
            bits6 = 6'($urandom_range(ENC_CMP + 1, 63));
            push_req({FORM_ENC, bits6}, 1'b0);
        end
        else if (pick < 88)
        begin
            push_object($urandom_range(0, 2));
            if (obj_reqs.size() > 1)
            begin
                cut = $urandom_range(1, obj_reqs.size() - 1);
                while (obj_reqs.size() > cut)
                    void'(obj_reqs.pop_back());
            end
            push_req(8'($urandom_range(0, 255)), 1'b1);
        end
        else if (pick < 93)
        begin
            push_req(8'($urandom_range(0, 255)), 1'b1);
        end
        else
        begin
            repeat ($urandom_range(1, 4))
                push_req(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        end
    endfunction

    task automatic send_req(input logic [7:0] b, input logic fin, input logic typed,
                            input logic hit, input result_t want);
        int gap;
        // Every fourth stretch of sixty requests goes out back to back.
        if ((requests_sent / 60) % 4 == 3)
            gap = 0;
        else
            gap = $urandom_range(0, 7);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        in_byte    <= b;
        stream_end <= fin;
        row_typed  <= typed;
        row_hit    <= hit;
        row_want   <= want;
        do @(posedge clk); while (!in_ready);
        requests_sent++;
    endtask

    task automatic wait_drained();
        do @(negedge clk); while (awaited_results.size() != 0);
        @(posedge clk);
    endtask

    initial
    begin : request_source
        int  random_sent;
        bit  paused;
        random_sent = 0;
        paused      = 1'b0;
        parser_clear();

        // Empty string, then a two-byte string with both byte extremes.
        directed_rows.push_back(table_row(8'h00, 1'b0, 1'b1, 1'b1,
            mk_result(KIND_STR_HDR, 0, 0, 0, 0, 0, 1'b1)));
        directed_rows.push_back(table_row(8'h02, 1'b0, 1'b1, 1'b1,
            mk_result(KIND_STR_HDR, 2, 0, 0, 0, 0, 1'b0)));
        directed_rows.push_back(table_row(8'h00, 1'b0, 1'b0, 1'b0, '0));
        directed_rows.push_back(table_row(8'hFF, 1'b0, 1'b0, 1'b0, '0));
        // Stream end between objects.
        directed_rows.push_back(table_row(8'hA5, 1'b1, 1'b1, 1'b0, '0));
        // Integers: most negative 8-bit, most positive 16-bit, most negative 32-bit.
        directed_rows.push_back(table_row({FORM_ENC, ENC_INT8}, 1'b0, 1'b1, 1'b0, '0));
        directed_rows.push_back(table_row(8'h80, 1'b0, 1'b1, 1'b1,
            mk_result(KIND_INT, 0, 0, 32'hFFFF_FF80, 0, 0, 1'b1)));
        directed_rows.push_back(table_row({FORM_ENC, ENC_INT16}, 1'b0, 1'b1, 1'b0, '0));
        directed_rows.push_back(table_row(8'hFF, 1'b0, 1'b1, 1'b0, '0));
        directed_rows.push_back(table_row(8'h7F, 1'b0, 1'b1, 1'b1,
            mk_result(KIND_INT, 0, 0, 32'h0000_7FFF, 0, 0, 1'b1)));
        directed_rows.push_back(table_row({FORM_ENC, ENC_INT32}, 1'b0, 1'b1, 1'b0, '0));
        directed_rows.push_back(table_row(8'h00, 1'b0, 1'b1, 1'b0, '0));
        directed_rows.push_back(table_row(8'h00, 1'b0, 1'b1, 1'b0, '0));
        directed_rows.push_back(table_row(8'h00, 1'b0, 1'b1, 1'b0, '0));
        directed_rows.push_back(table_row(8'h80, 1'b0, 1'b1, 1'b1,
            mk_result(KIND_INT, 0, 0, 32'h8000_0000, 0, 0, 1'b1)));
        // Unknown encoding.
        directed_rows.push_back(table_row(8'hC4, 1'b0, 1'b1, 1'b1,
            mk_result(KIND_ERROR, 0, 0, 0, 0, CAUSE_UNKNOWN_ENC, 1'b1)));
        // All-ones 32-bit length.
        directed_rows.push_back(table_row({FORM_LEN32, 6'd0}, 1'b0, 1'b1, 1'b0, '0));
        directed_rows.push_back(table_row(8'hFF, 1'b0, 1'b1, 1'b0, '0));
        directed_rows.push_back(table_row(8'hFF, 1'b0, 1'b1, 1'b0, '0));
        directed_rows.push_back(table_row(8'hFF, 1'b0, 1'b1, 1'b0, '0));
        directed_rows.push_back(table_row(8'hFF, 1'b0, 1'b1, 1'b1,
            mk_result(KIND_ERROR, 0, 0, 0, 0, CAUSE_LEN_ERROR, 1'b1)));
        // Empty compressed blob whose raw length uses the encoding form as a 6-bit length.
        directed_rows.push_back(table_row({FORM_ENC, ENC_CMP}, 1'b0, 1'b1, 1'b0, '0));
        directed_rows.push_back(table_row(8'h00, 1'b0, 1'b1, 1'b0, '0));
        directed_rows.push_back(table_row(8'hC5, 1'b0, 1'b1, 1'b1,
            mk_result(KIND_CMP_HDR, 0, 5, 0, 0, 0, 1'b1)));
        // Stream ends after the first byte of a 14-bit length.
        directed_rows.push_back(table_row(8'h41, 1'b0, 1'b1, 1'b0, '0));
        directed_rows.push_back(table_row(8'h00, 1'b1, 1'b1, 1'b1,
            mk_result(KIND_ERROR, 0, 0, 0, 0, CAUSE_TRUNCATED, 1'b1)));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_req(directed_rows[i].b, directed_rows[i].fin, directed_rows[i].typed,
                     directed_rows[i].hit, directed_rows[i].want);

        while (random_sent < RANDOM_ITEMS)
        begin
            gen_object();
            foreach (obj_reqs[i])
            begin
                send_req(obj_reqs[i].b, obj_reqs[i].fin, 1'b0, 1'b0, '0);
                random_sent++;
            end
            // Once, after the long output hold, stop and let every result drain.
            if (!paused && long_hold_done && random_sent > 200)
            begin
                paused = 1'b1;
                in_valid <= 1'b0;
                wait_drained();
            end
        end
        in_valid <= 1'b0;

        wait_drained();
        repeat (10) @(posedge clk);
        $display("Sent %0d requests (%0d from the table) and checked %0d results",
                 requests_taken, directed_rows.size(), results_checked);
        $display("Covered strings, integers, compressed blobs, errors and stream ends");
        if (diff_count == 0 && awaited_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin : result_sink
        int stall;
        int taken;
        taken = 0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (!long_hold_done && taken >= 120)
            begin
                // Long hold so that the result queue fills and the input stalls.
                stall          = HOLD_CYCLES;
                long_hold_done = 1'b1;
            end
            else if ((taken / 40) % 4 == 2)
            begin
                stall = 0;
            end
            else
            begin
                stall = $urandom_range(0, 7);
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            taken++;
        end
    end

endmodule
